@@ hw/rtl/lru_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared constants and the link structures that run along the cell row.
// ----------------------------------------------------------------------------
package lru_pkg;

  localparam int CFG_W         = 5;
  localparam int FAULT_W       = 32;
  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 20;
  localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

  // Status that ripples from the most recent cell toward the least recent.
  typedef struct packed {
    logic match_seen;  // some cell nearer the top holds the referenced page
    logic full_seen;   // the cell at the frame limit holds a resident page
    logic valid;       // the sending cell holds a resident page
  } link_t;

  // Decision broadcast back to every cell.
  typedef struct packed {
    logic hit;
    logic full;
  } ctrl_t;

endpackage
`default_nettype wire

@@ hw/rtl/lru_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU recency cell
// Holds one stack position and moves the neighbor's entry in when it shifts.
// ----------------------------------------------------------------------------
module lru_cell #(
  parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF,
  parameter int LIM_W     = 5,
  parameter int IDX       = 0
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       upd,
  input  wire lru_pkg::ctrl_t       ctrl,
  input  wire  [LIM_W-1:0]          lim,
  input  wire  [PAGE_BITS-1:0]      page,
  input  wire lru_pkg::link_t       link_in,
  input  wire  [PAGE_BITS-1:0]      data_in,
  input  wire  [PAGE_BITS-1:0]      evict_in,
  output lru_pkg::link_t            link_out,
  output logic [PAGE_BITS-1:0]      data_out,
  output logic [PAGE_BITS-1:0]      evict_out
);

  localparam logic [LIM_W-1:0] POS = LIM_W'(IDX + 1);

  logic [PAGE_BITS-1:0] entry_r, entry_nxt;
  logic                 valid_r, valid_nxt;
  logic                 match;
  logic                 shift;

  assign match = valid_r && (entry_r == page);

  // On a hit everything above the hit moves down; on a miss the row moves
  // down to the first empty cell, or to the last resident one when full.
  always_comb begin
    shift = 1'b0;
    if (!link_in.match_seen) begin
      if (ctrl.hit) begin
        shift = 1'b1;
      end else if (ctrl.full) begin
        shift = valid_r;
      end else begin
        shift = link_in.valid;
      end
    end
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (upd && shift) begin
      entry_nxt = data_in;
      valid_nxt = valid_r | link_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign link_out.match_seen = link_in.match_seen | match;
  assign link_out.full_seen  = link_in.full_seen | (valid_r && (lim == POS));
  assign link_out.valid      = valid_r;
  assign data_out            = entry_r;
  assign evict_out           = valid_r ? entry_r : evict_in;

endmodule
`default_nettype wire

@@ hw/rtl/lru_page_replacement.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page replacement
// Fully associative recency stack built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction on in_* carries one page reference. Every
//   reference produces exactly one result transaction on out_*: the fault
//   flag, the running saturating fault count and the evicted page, if any.
//   The cfg_* port writes the number of usable frames; a value of zero acts
//   as one and values above FRAMES act as FRAMES. Write it only while idle.
// Timing:
//   A reference is compared against all resident pages at once and the
//   stack is shifted in the same cycle, so the block takes one reference
//   per clock while the receiver does not stall. The result appears in the
//   output register on the cycle after acceptance. The critical path is the
//   page compare followed by the hit and full ripple along the cell row.
// Reset and flow control:
//   Reset empties the stack, clears the fault count and sets the frame limit
//   to 16. When the receiver stalls, the held result keeps in_stall high, so
//   no reference is taken until the result has been accepted.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
  parameter int FRAMES    = lru_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_wr_en,
  input  wire  [lru_pkg::CFG_W-1:0]    cfg_wr_data,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [PAGE_BITS-1:0]         in_page,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic                         out_fault,
  output logic [lru_pkg::FAULT_W-1:0]  out_fault_count,
  output logic                         out_evicted_valid,
  output logic [PAGE_BITS-1:0]         out_evicted_page
);

  localparam int LIM_W = (FRAMES < 2) ? 1 : $clog2(FRAMES + 1);

  logic [lru_pkg::CFG_W-1:0]   frames_r;
  logic [LIM_W-1:0]            lim;
  logic                        in_accept;
  lru_pkg::ctrl_t              ctrl;
  lru_pkg::link_t              link_w [FRAMES+1];
  logic [PAGE_BITS-1:0]        data_w [FRAMES+1];
  logic [PAGE_BITS-1:0]        ev_w   [FRAMES+1];
  logic [FRAMES-1:0]           valid_vec;

  logic [lru_pkg::FAULT_W-1:0] fault_cnt_r, fault_cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_fault_r;
  logic                        out_ev_valid_r;
  logic [PAGE_BITS-1:0]        out_ev_page_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= lru_pkg::FRAMES_RESET;
    end else if (cfg_wr_en) begin
      frames_r <= cfg_wr_data;
    end
  end

  // Effective frame limit, clamped to one through FRAMES.
  always_comb begin
    if (frames_r == '0) begin
      lim = LIM_W'(1);
    end else if (32'(frames_r) > FRAMES) begin
      lim = LIM_W'(FRAMES);
    end else begin
      lim = LIM_W'(frames_r);
    end
  end

  // A new reference is taken whenever the output register is free or
  // being emptied in this cycle.
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  // Head of the row: the new page enters cell 0, which always loads.
  assign link_w[0] = '{match_seen: 1'b0, full_seen: 1'b0, valid: 1'b1};
  assign data_w[0] = in_page;
  assign ev_w[0]   = '0;

  genvar g;
  generate
    for (g = 0; g < FRAMES; g++) begin : g_cell
      lru_cell #(
        .PAGE_BITS (PAGE_BITS),
        .LIM_W     (LIM_W),
        .IDX       (g)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (in_accept),
        .ctrl      (ctrl),
        .lim       (lim),
        .page      (in_page),
        .link_in   (link_w[g]),
        .data_in   (data_w[g]),
        .evict_in  (ev_w[g]),
        .link_out  (link_w[g+1]),
        .data_out  (data_w[g+1]),
        .evict_out (ev_w[g+1])
      );
      assign valid_vec[g] = link_w[g+1].valid;
    end
  endgenerate

  // The tail of the row gives the hit and full decisions and, because the
  // resident cells form a contiguous run from the top, the least recent
  // resident page.
  assign ctrl.hit  = link_w[FRAMES].match_seen;
  assign ctrl.full = link_w[FRAMES].full_seen;

  always_comb begin
    fault_cnt_nxt = fault_cnt_r;
    if (in_accept && !ctrl.hit && (fault_cnt_r != '1)) begin
      fault_cnt_nxt = fault_cnt_r + 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fault_cnt_r <= fault_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_fault_r    <= !ctrl.hit;
      out_ev_valid_r <= !ctrl.hit && ctrl.full;
      out_ev_page_r  <= (!ctrl.hit && ctrl.full) ? ev_w[FRAMES] : '0;
    end
  end

  // The counter only moves on acceptance, which is blocked while a result
  // waits, so it still matches the held result.
  assign out_valid         = out_valid_r;
  assign out_fault         = out_fault_r;
  assign out_fault_count   = fault_cnt_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;

  // Resident cells always form one run starting at the top of the stack.
  a_valid_run : assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec & (valid_vec + 1'b1)) == '0))
    else $error("resident cells are not contiguous from the top");

  // A hit neither grows nor shrinks the resident set.
  a_hit_keeps_occ : assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && ctrl.hit) |=> (valid_vec == $past(valid_vec)))
    else $error("hit changed the resident set");

  // The referenced page is on top after every transaction.
  a_top_is_page : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (valid_vec[0] && (data_w[1] == $past(in_page))))
    else $error("referenced page not at the top of the stack");

  // A miss advances the fault count unless it has saturated.
  a_fault_count : assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !ctrl.hit) |=>
      ((fault_cnt_r != $past(fault_cnt_r)) || (fault_cnt_r == '1)))
    else $error("fault count did not advance on a miss");

  // An eviction only ever comes with a fault.
  a_evict_fault : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_ev_valid_r || out_fault_r))
    else $error("eviction reported without a fault");

endmodule
`default_nettype wire
